### design/erc_pkg.sv
`default_nettype none

package erc_pkg;

  // Field widths of one input item and one result item.
  localparam int WIDTH_W = 16;
  localparam int DIST_W  = 11;
  localparam int CNT_W   = 4;

  // Default burst length.
  localparam int SAMPLES_DEF = 10;

  // Microseconds to centimetres: floor(w / 58) == (w * CM_RECIP) >> CM_SHIFT
  // for every 16-bit w, since 28 * 65535 < 2**28 / 58.
  localparam int RECIP_W  = 23;
  localparam int CM_SHIFT = 28;
  localparam logic [RECIP_W-1:0] CM_RECIP = 23'd4628198;
  localparam int PROD_W   = WIDTH_W + RECIP_W;

  // Two distances agree when they differ by at most this many centimetres.
  localparam logic [DIST_W-1:0] NEAR_CM = 11'd1;

  // Support counts saturate here.
  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;
  localparam logic [CNT_W-1:0] CNT_ONE = 4'd1;

  // One entry of the sample memory: distance and its support count.
  typedef struct packed {
    logic [DIST_W-1:0] range_cm;
    logic [CNT_W-1:0]  cnt;
  } erc_entry_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STORE,
    ST_PICK
  } erc_state_t;

  // True when two distances lie within NEAR_CM of each other.
  function automatic logic is_near(input logic [DIST_W-1:0] a,
                                   input logic [DIST_W-1:0] b);
    logic [DIST_W-1:0] diff;
    diff = (a >= b) ? (a - b) : (b - a);
    return diff <= NEAR_CM;
  endfunction

  // Saturating increment of a support count.
  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c,
                                               input logic inc);
    logic [CNT_W-1:0] res;
    res = c;
    if (inc && (c != CNT_MAX)) begin
      res = c + CNT_ONE;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### design/echo_range_consensus_filter.sv
`default_nettype none

// Channel   Handshake              Ports
// -------   ---------------------  ----------------------------------------
// input     start && !busy         in_echo_width_us
// result    out_valid, one cycle   out_distance_cm, out_support_count
//
// The k-th item of a burst (k from 0) keeps busy high for one read-modify-write
// pass of the sample memory over the k earlier entries at one entry a cycle,
// then the write of the new entry. The last item of a burst adds a pass over
// the memory that picks the best entry; out_valid rises at the same edge at
// which busy falls.
// Reset (rst_n low at a clock edge) empties the burst; the memory is not
// cleared, as no entry is read before the burst writes it.
// The receiver cannot stall; a result is shown for one cycle only.

module echo_range_consensus_filter #(
  parameter int SAMPLES = erc_pkg::SAMPLES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [erc_pkg::WIDTH_W-1:0] in_echo_width_us,
  output logic                             out_valid,
  output logic      [erc_pkg::DIST_W-1:0]  out_distance_cm,
  output logic      [erc_pkg::CNT_W-1:0]   out_support_count
);

  localparam int AW    = $clog2(SAMPLES);
  localparam int IDX_W = $clog2(SAMPLES + 1);

  logic                       accept;
  logic [erc_pkg::DIST_W-1:0] dist_cm;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [AW-1:0]              mem_raddr;
  erc_pkg::erc_entry_t        mem_wdata;
  erc_pkg::erc_entry_t        mem_rdata;

  assign accept = start && !busy;

  // Pulse width to distance.
  erc_conv u_conv (
    .clk      (clk),
    .load     (accept),
    .width_us (in_echo_width_us),
    .dist_cm  (dist_cm)
  );

  // Distances of the burst and their support counts.
  erc_mem #(
    .DEPTH (SAMPLES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer for the count updates and the final pick.
  erc_ctrl #(
    .SAMPLES (SAMPLES),
    .AW      (AW),
    .IDX_W   (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .dist_cm   (dist_cm),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (out_valid),
    .res_dist  (out_distance_cm),
    .res_cnt   (out_support_count)
  );

endmodule

`default_nettype wire

### design/erc_conv.sv
`default_nettype none

module erc_conv (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic [erc_pkg::WIDTH_W-1:0] width_us,
  output logic      [erc_pkg::DIST_W-1:0]  dist_cm
);

  logic [erc_pkg::PROD_W-1:0] prod;
  logic [erc_pkg::DIST_W-1:0] dist_r;

  // Division by 58 as a multiplication by its scaled reciprocal.
  assign prod = erc_pkg::PROD_W'(width_us) * erc_pkg::PROD_W'(erc_pkg::CM_RECIP);

  // The distance is held for the whole time the item is processed.
  always_ff @(posedge clk) begin
    if (load) begin
      dist_r <= prod[erc_pkg::CM_SHIFT +: erc_pkg::DIST_W];
    end
  end

  assign dist_cm = dist_r;

endmodule

`default_nettype wire

### design/erc_mem.sv
`default_nettype none

module erc_mem #(
  parameter int DEPTH = erc_pkg::SAMPLES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire erc_pkg::erc_entry_t wdata,
  input  wire logic [AW-1:0]       raddr,
  output erc_pkg::erc_entry_t      rdata
);

  erc_pkg::erc_entry_t mem [DEPTH];
  erc_pkg::erc_entry_t rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/erc_ctrl.sv
`default_nettype none

module erc_ctrl #(
  parameter int SAMPLES = erc_pkg::SAMPLES_DEF,
  parameter int AW      = $clog2(SAMPLES),
  parameter int IDX_W   = $clog2(SAMPLES + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic [erc_pkg::DIST_W-1:0] dist_cm,
  output logic                            busy,
  output logic                            mem_we,
  output logic      [AW-1:0]              mem_waddr,
  output erc_pkg::erc_entry_t             mem_wdata,
  output logic      [AW-1:0]              mem_raddr,
  input  wire erc_pkg::erc_entry_t        mem_rdata,
  output logic                            res_valid,
  output logic      [erc_pkg::DIST_W-1:0] res_dist,
  output logic      [erc_pkg::CNT_W-1:0]  res_cnt
);

  localparam logic [IDX_W-1:0] IDX_END  = IDX_W'(SAMPLES);
  localparam logic [AW-1:0]    LAST_POS = AW'(SAMPLES - 1);
  localparam logic [AW-1:0]    POS_ONE  = AW'(1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  erc_pkg::erc_state_t state_r, state_nxt;

  logic [AW-1:0]              loaded_r, loaded_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic                       rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]              rd_pos_r, rd_pos_nxt;
  logic [erc_pkg::CNT_W-1:0]  self_cnt_r, self_cnt_nxt;
  logic [erc_pkg::CNT_W-1:0]  best_cnt_r, best_cnt_nxt;
  logic [erc_pkg::DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [IDX_W-1:0] scan_end;
  logic             near_hit;
  logic             issue_rd;

  // The scan over earlier samples of the burst stops at the new sample.
  assign scan_end = IDX_W'(loaded_r);
  assign near_hit = erc_pkg::is_near(mem_rdata.range_cm, dist_cm);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      erc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = erc_pkg::ST_SCAN;
        end
      end
      erc_pkg::ST_SCAN: begin
        if (idx_r == scan_end) begin
          state_nxt = erc_pkg::ST_STORE;
        end
      end
      erc_pkg::ST_STORE: begin
        if (loaded_r == LAST_POS) begin
          state_nxt = erc_pkg::ST_PICK;
        end else begin
          state_nxt = erc_pkg::ST_IDLE;
        end
      end
      erc_pkg::ST_PICK: begin
        if (idx_r == IDX_END) begin
          state_nxt = erc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = erc_pkg::ST_IDLE;
    endcase
  end

  // Memory accesses and sequencing registers. A read of one entry is written
  // back in the next cycle while the next entry is read, so the two never
  // touch the same entry.
  always_comb begin
    issue_rd      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = rd_pos_r;
    mem_wdata     = mem_rdata;
    loaded_nxt    = loaded_r;
    idx_nxt       = idx_r;
    self_cnt_nxt  = self_cnt_r;
    best_cnt_nxt  = best_cnt_r;
    best_dist_nxt = best_dist_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      erc_pkg::ST_IDLE: begin
        idx_nxt      = '0;
        self_cnt_nxt = erc_pkg::CNT_ONE;
      end
      erc_pkg::ST_SCAN: begin
        issue_rd = (idx_r != scan_end);
        if (issue_rd) begin
          idx_nxt = idx_r + IDX_ONE;
        end
        // Each earlier sample near the new one gains a vote, and gives one.
        if (rd_pend_r) begin
          mem_we        = 1'b1;
          mem_wdata.cnt = erc_pkg::cnt_inc(mem_rdata.cnt, near_hit);
          self_cnt_nxt  = erc_pkg::cnt_inc(self_cnt_r, near_hit);
        end
      end
      erc_pkg::ST_STORE: begin
        mem_we             = 1'b1;
        mem_waddr          = loaded_r;
        mem_wdata.range_cm = dist_cm;
        mem_wdata.cnt      = self_cnt_r;
        idx_nxt            = '0;
        best_cnt_nxt       = '0;
        if (loaded_r != LAST_POS) begin
          loaded_nxt = loaded_r + POS_ONE;
        end
      end
      erc_pkg::ST_PICK: begin
        issue_rd = (idx_r != IDX_END);
        if (issue_rd) begin
          idx_nxt = idx_r + IDX_ONE;
        end
        // Strictly greater, so the earliest of equal counts is kept.
        if (rd_pend_r && (mem_rdata.cnt > best_cnt_r)) begin
          best_cnt_nxt  = mem_rdata.cnt;
          best_dist_nxt = mem_rdata.range_cm;
        end
        if (idx_r == IDX_END) begin
          out_valid_nxt = 1'b1;
          loaded_nxt    = '0;
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
    rd_pend_nxt = issue_rd;
    rd_pos_nxt  = idx_r[AW-1:0];
  end

  assign mem_raddr = idx_r[AW-1:0];
  assign busy      = (state_r != erc_pkg::ST_IDLE);
  assign res_valid = out_valid_r;
  assign res_dist  = best_dist_r;
  assign res_cnt   = best_cnt_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= erc_pkg::ST_IDLE;
      loaded_r    <= '0;
      idx_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      idx_r       <= idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_pos_r    <= rd_pos_nxt;
    self_cnt_r  <= self_cnt_nxt;
    best_cnt_r  <= best_cnt_nxt;
    best_dist_r <= best_dist_nxt;
  end

endmodule

`default_nettype wire
